// ===== src/sss_pkg.sv =====
// shared types, constants and font lookup for the seven-segment scan serializer
package sss_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int FRAME_BITS  = 16;
  localparam int POS_W       = 3;
  localparam int GLYPH_W     = 6;
  localparam int BITPOS_W    = 4;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

  typedef logic [FRAME_BITS-1:0] frame_t;

  // frame handoff from the builder to the shifter
  typedef struct packed {
    logic   vld;
    frame_t bits;
  } frame_req_t;

  // font pattern for one glyph, blank above the last glyph
  function automatic logic [7:0] font_pattern(input logic [GLYPH_W-1:0] glyph);
    logic [7:0] pat;
    unique case (glyph)
      6'd0:  pat = 8'h3F;
      6'd1:  pat = 8'h06;
      6'd2:  pat = 8'h5B;
      6'd3:  pat = 8'h4F;
      6'd4:  pat = 8'h66;
      6'd5:  pat = 8'h6D;
      6'd6:  pat = 8'h7D;
      6'd7:  pat = 8'h07;
      6'd8:  pat = 8'h7F;
      6'd9:  pat = 8'h6F;
      6'd10: pat = 8'h77;
      6'd11: pat = 8'h7C;
      6'd12: pat = 8'h39;
      6'd13: pat = 8'h5E;
      6'd14: pat = 8'h79;
      6'd15: pat = 8'h71;
      6'd16: pat = 8'h00;
      6'd17: pat = 8'h40;
      6'd18: pat = 8'h76;
      6'd19: pat = 8'h1E;
      6'd20: pat = 8'h70;
      6'd21: pat = 8'h38;
      6'd22: pat = 8'h37;
      6'd23: pat = 8'h5C;
      6'd24: pat = 8'h73;
      6'd25: pat = 8'h3E;
      6'd26: pat = 8'h78;
      6'd27: pat = 8'h3D;
      6'd28: pat = 8'h67;
      6'd29: pat = 8'h50;
      6'd30: pat = 8'h37;
      6'd31: pat = 8'h6E;
      6'd32: pat = 8'hBF;
      6'd33: pat = 8'h86;
      6'd34: pat = 8'hDB;
      6'd35: pat = 8'hCF;
      6'd36: pat = 8'hE6;
      6'd37: pat = 8'hED;
      6'd38: pat = 8'hFD;
      6'd39: pat = 8'h87;
      6'd40: pat = 8'hFF;
      6'd41: pat = 8'hEF;
      6'd42: pat = 8'h46;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/sss_frame.sv =====
// input register, digit buffer, scan position and frame builder
module sss_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [2:0]            in_slot,
  input  logic [5:0]            in_glyph,
  input  logic                  common_anode,
  output sss_pkg::frame_req_t   frame_req,
  input  logic                  frame_rdy
);
  import sss_pkg::*;

  logic               stg_vld_r;
  logic               stg_cmd_r;
  logic [POS_W-1:0]   stg_slot_r;
  logic [GLYPH_W-1:0] stg_glyph_r;
  logic [GLYPH_W-1:0] buf_r [DIGIT_COUNT];
  logic [POS_W-1:0]   scan_pos_r;
  logic [POS_W-1:0]   scan_pos_nxt;
  logic               is_scan;
  logic               load;
  logic               consume;
  logic [7:0]         mask;
  logic [7:0]         sel;
  logic [7:0]         seg;

  // handshake: a write leaves at once, a scan leaves when the shifter takes it
  assign is_scan  = stg_vld_r && (stg_cmd_r == CMD_SCAN);
  assign load     = is_scan && frame_rdy;
  assign consume  = load || (stg_vld_r && (stg_cmd_r == CMD_WRITE));
  assign in_ready = !stg_vld_r || consume;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_ready) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_cmd_r   <= in_cmd;
      stg_slot_r  <= in_slot;
      stg_glyph_r <= in_glyph;
    end
  end

  // digit buffer, entry i resets to glyph i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        buf_r[i] <= GLYPH_W'(i);
      end
    end else if (stg_vld_r && (stg_cmd_r == CMD_WRITE)) begin
      buf_r[stg_slot_r] <= stg_glyph_r;
    end
  end

  // scan position wraps after the last digit
  assign scan_pos_nxt = (scan_pos_r == LAST_POS) ? '0 : scan_pos_r + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_pos_r <= '0;
    end else if (load) begin
      scan_pos_r <= scan_pos_nxt;
    end
  end

  // select byte then segment byte, both through the polarity mask
  assign mask = {8{common_anode}};
  assign sel  = ~mask ^ (8'd1 << scan_pos_r);
  assign seg  = mask ^ font_pattern(buf_r[scan_pos_r]);

  assign frame_req.vld  = is_scan;
  assign frame_req.bits = {sel, seg};

endmodule

// ===== src/sss_shift.sv =====
// output shifter: one frame bit per word, msb first
module sss_shift (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sss_pkg::frame_req_t   frame_req,
  output logic                  frame_rdy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bit,
  output logic [3:0]            out_pos,
  output logic                  out_last
);
  import sss_pkg::*;

  logic                busy_r;
  frame_t              frame_r;
  logic [BITPOS_W-1:0] cnt_r;
  logic                take;
  logic                last;

  assign take      = busy_r && out_ready;
  assign last      = (cnt_r == BITPOS_W'(FRAME_BITS - 1));
  assign frame_rdy = !busy_r || (take && last);

  // busy flag and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (frame_rdy && frame_req.vld) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= !last;
      cnt_r  <= cnt_r + BITPOS_W'(1);
    end
  end

  // frame shift register
  always_ff @(posedge clk) begin
    if (frame_rdy && frame_req.vld) begin
      frame_r <= frame_req.bits;
    end else if (take) begin
      frame_r <= {frame_r[FRAME_BITS-2:0], 1'b0};
    end
  end

  assign out_valid = busy_r;
  assign out_bit   = frame_r[FRAME_BITS-1];
  assign out_pos   = cnt_r;
  assign out_last  = last;

endmodule

// ===== src/seven_segment_scan_serializer.sv =====
// top level of the seven-segment scan serializer
//
//  channel  | direction | fields
//  ---------+-----------+--------------------------------------------------
//  in_      | sink      | tuser: cmd; tdata: digit_slot, glyph_code
//  out_     | source    | tdata: serial_bit, bit_position; tlast: latch_pulse
//  cfg_     | sink      | data: common_anode, always ready
//
// a scan tick turns into 16 words, one per cycle while out_tready is high;
// the frame builder hands the next frame to the shifter on the edge that
// takes the last bit, so back-to-back scans stream with no gap.
// buffer writes are accepted while a frame is shifting, unless a scan waits in the input register.
// reset (rst_n low, synchronous) loads glyph i into digit i, position 0.
// a stall on out_ holds the shifter; the input register then fills and waits.
module seven_segment_scan_serializer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] cmd
  input  logic [15:0] in_tdata,   // [2:0] digit_slot, [8:3] glyph_code, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] serial_bit, [4:1] bit_position, rest zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import sss_pkg::*;

  logic       common_anode_r;
  frame_req_t frame_req;
  logic       frame_rdy;
  logic       out_bit;
  logic [3:0] out_pos;

  // polarity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_anode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      common_anode_r <= cfg_data;
    end
  end

  sss_frame u_frame (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_cmd       (in_tuser),
    .in_slot      (in_tdata[2:0]),
    .in_glyph     (in_tdata[8:3]),
    .common_anode (common_anode_r),
    .frame_req    (frame_req),
    .frame_rdy    (frame_rdy)
  );

  sss_shift u_shift (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_req (frame_req),
    .frame_rdy (frame_rdy),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_bit   (out_bit),
    .out_pos   (out_pos),
    .out_last  (out_tlast)
  );

  // output word packing
  assign out_tdata = {3'b000, out_pos, out_bit};

endmodule
